// File: design/ilir_pkg.sv
// Shared types and constants for the indexed list block.
package ilir_pkg;

    localparam int DEPTH   = 16;
    localparam int ELEM_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OPC_W   = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 3'd0,
        OP_PUSH   = 3'd1,
        OP_REMOVE = 3'd2,
        OP_POP    = 3'd3,
        OP_WRITE  = 3'd4,
        OP_READ   = 3'd5,
        OP_CLEAR  = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_DN,
        ST_RDW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ELEM_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic               err;
        logic [ELEM_W-1:0]  rd;
        logic [CNT_W-1:0]   count;
    } res_t;

endpackage

// File: design/indexed_list_insert_remove_top.sv
// Top level of the indexed list: sequencer, slot memory and result register.
//
//  channel | prefix | ports                                      | accepted when
//  input   | s_     | s_valid s_ready s_opcode s_position s_value | s_valid && s_ready
//  result  | m_     | m_valid m_ready m_error m_read_value        | m_valid && m_ready
//          |        | m_entry_count                              |
//
// One beat in, one beat out. With entries to move, insert and push shift them up and remove
// shifts them down, one slot per cycle through the single write port, and the last read is
// drained before the result is built. Read and pop go through the registered read port.
// Reset clears the count and the per-slot valid bits at once; no clearing pass.
// A stalled result sits in the output register; the next beat is taken meanwhile.
module indexed_list_insert_remove_top
    import ilir_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OPC_W-1:0]   s_opcode,
    input  logic [POS_W-1:0]   s_position,
    input  logic [VALUE_W-1:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_error,
    output logic [ELEM_W-1:0]  m_read_value,
    output logic [CNT_W-1:0]   m_entry_count
);

    mem_req_t          mem_req;
    logic [ELEM_W-1:0] mem_rdata;
    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              m_valid_reg;
    res_t              out_reg;

    ilir_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_opcode   (s_opcode),
        .in_position (s_position),
        .in_value    (s_value),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    ilir_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rdata   (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_error       = out_reg.err;
    assign m_read_value  = out_reg.rd;
    assign m_entry_count = out_reg.count;

endmodule

// File: design/ilir_ram.sv
// Slot memory: one write and one registered read port, per-slot valid bits for zero reset.
module ilir_ram
    import ilir_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mem_req_t          req,
    output logic [ELEM_W-1:0] rdata
);

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [ELEM_W-1:0] rd_data_reg;
    logic              rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
            rd_vld_reg  <= vld_reg[req.raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (req.we) begin
            vld_reg[req.waddr] <= 1'b1;
        end
    end

    assign rdata = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: design/ilir_ctrl.sv
// Operation sequencer: checks, shifts entries through the slot memory, builds the result.
module ilir_ctrl
    import ilir_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OPC_W-1:0]   in_opcode,
    input  logic [POS_W-1:0]   in_position,
    input  logic [VALUE_W-1:0] in_value,
    output mem_req_t           mem_req,
    input  logic [ELEM_W-1:0]  mem_rdata,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]  wdst_reg, wdst_next;
    logic               pend_reg, pend_next;
    logic [ELEM_W-1:0]  val_reg, val_next;
    logic               err_reg, err_next;
    logic [ELEM_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]   pos_in;
    logic [CNT_W-1:0]   idx_dec;
    logic               accept;

    assign pos_in  = CNT_W'(in_position);
    assign idx_dec = idx_reg - CNT_W'(1);
    assign accept  = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        wdst_reg <= wdst_next;
        val_reg  <= val_next;
        err_reg  <= err_next;
        rd_reg   <= rd_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        wdst_next  = wdst_reg;
        pend_next  = pend_reg;
        val_next   = val_reg;
        err_next   = err_reg;
        rd_next    = rd_reg;
        mem_req    = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    err_next  = 1'b0;
                    rd_next   = '0;
                    pend_next = 1'b0;
                    val_next  = ELEM_W'(in_value);
                    unique case (in_opcode)
                        OP_INSERT, OP_PUSH: begin
                            if (count_reg >= DEPTH_CNT ||
                                (in_opcode == OP_INSERT && pos_in > count_reg)) begin
                                err_next   = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                idx_next   = count_reg;
                                pos_next   = (in_opcode == OP_PUSH) ? count_reg : pos_in;
                                state_next = ST_UP;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_in >= count_reg) begin
                                err_next   = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                idx_next   = pos_in + CNT_W'(1);
                                state_next = ST_DN;
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                err_next   = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = ADDR_W'(count_reg - CNT_W'(1));
                                count_next    = count_reg - CNT_W'(1);
                                state_next    = ST_RDW;
                            end
                        end
                        OP_WRITE: begin
                            if (pos_in >= DEPTH_CNT) begin
                                err_next = 1'b1;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = ADDR_W'(pos_in);
                                mem_req.wdata = ELEM_W'(in_value);
                            end
                            state_next = ST_DONE;
                        end
                        OP_READ: begin
                            if (pos_in >= DEPTH_CNT) begin
                                err_next   = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = ADDR_W'(pos_in);
                                state_next    = ST_RDW;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            err_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_UP: begin
                mem_req.we    = pend_reg;
                mem_req.waddr = wdst_reg;
                mem_req.wdata = mem_rdata;
                if (idx_reg > pos_reg) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ADDR_W'(idx_dec);
                    pend_next     = 1'b1;
                    wdst_next     = ADDR_W'(idx_reg);
                    idx_next      = idx_dec;
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = ADDR_W'(pos_reg);
                    mem_req.wdata = val_reg;
                    count_next    = count_reg + CNT_W'(1);
                    state_next    = ST_DONE;
                end
            end
            ST_DN: begin
                mem_req.we    = pend_reg;
                mem_req.waddr = wdst_reg;
                mem_req.wdata = mem_rdata;
                if (idx_reg < count_reg) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ADDR_W'(idx_reg);
                    pend_next     = 1'b1;
                    wdst_next     = ADDR_W'(idx_dec);
                    idx_next      = idx_reg + CNT_W'(1);
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_RDW: begin
                rd_next    = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.err   = err_reg;
    assign res.rd    = err_reg ? '0 : rd_reg;
    assign res.count = count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("live count above capacity");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.we && mem_req.re && mem_req.waddr == mem_req.raddr))
        else $error("read and write to the same slot in one cycle");

    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> !mem_req.we && !mem_req.re)
        else $error("memory access while result is pending");

    a_done_count_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && $past(state_reg == ST_DONE) |-> $stable(count_reg))
        else $error("count moved while result is pending");

endmodule

// File: tb/sv/tb_indexed_list_insert_remove_top.sv
// Testbench for the indexed list: directed and random list operations against a local predictor.
`timescale 1ns / 1ps

module tb_indexed_list_insert_remove_top
    import ilir_pkg::*;
();

    localparam int IDLE_MAX    = 19;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int POS_MAX     = (1 << POS_W) - 1;
    localparam int OPC_MAX     = (1 << OPC_W) - 1;
    localparam logic [OPC_W-1:0] OPC_UNDEF = OPC_W'(OPC_MAX);

    typedef enum int {TR_GROW, TR_SHRINK, TR_CHURN} traffic_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [OPC_W-1:0]   s_opcode;
    logic [POS_W-1:0]   s_position;
    logic [VALUE_W-1:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic               m_error;
    logic [ELEM_W-1:0]  m_read_value;
    logic [CNT_W-1:0]   m_entry_count;

    // shadow of the list
    logic [ELEM_W-1:0] list_slots [DEPTH];
    int                list_count;
    res_t              expected_results [$];

    bit src_idle;
    bit sink_idle;
    int sink_wait;
    int quiet_cycles;
    int mismatches;
    int beats_checked;
    int ops_rejected;
    int full_hits;
    int op_hits [OPC_MAX + 1];

    indexed_list_insert_remove_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_error       (m_error),
        .m_read_value  (m_read_value),
        .m_entry_count (m_entry_count)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic res_t list_apply(input logic [OPC_W-1:0] opc,
                                        input logic [POS_W-1:0] pos,
                                        input logic [VALUE_W-1:0] val);
        res_t r;
        int   at;
        int   i;
        r = '0;
        op_hits[opc]++;
        case (opc)
            OP_INSERT, OP_PUSH: begin
                at = (opc == OP_PUSH) ? list_count : int'(pos);
                if (list_count >= DEPTH) begin
                    r.err = 1'b1;
                    full_hits++;
                end else if (at > list_count) begin
                    r.err = 1'b1;
                end else begin
                    for (i = list_count; i > at; i--)
                        list_slots[i] = list_slots[i-1];
                    list_slots[at] = val[ELEM_W-1:0];
                    list_count++;
                end
            end
            OP_REMOVE: begin
                if (int'(pos) >= list_count) begin
                    r.err = 1'b1;
                end else begin
                    for (i = int'(pos); i + 1 < list_count; i++)
                        list_slots[i] = list_slots[i+1];
                    list_count--;
                end
            end
            OP_POP: begin
                if (list_count == 0) begin
                    r.err = 1'b1;
                end else begin
                    list_count--;
                    r.rd = list_slots[list_count];
                end
            end
            OP_WRITE: begin
                if (int'(pos) >= DEPTH)
                    r.err = 1'b1;
                else
                    list_slots[pos[ADDR_W-1:0]] = val[ELEM_W-1:0];
            end
            OP_READ: begin
                if (int'(pos) >= DEPTH)
                    r.err = 1'b1;
                else
                    r.rd = list_slots[pos[ADDR_W-1:0]];
            end
            OP_CLEAR: list_count = 0;
            default:  r.err = 1'b1;
        endcase
        if (r.err)
            ops_rejected++;
        r.count = CNT_W'(list_count);
        return r;
    endfunction

    task automatic send_op(input logic [OPC_W-1:0] opc, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] val);
        int gap;
        gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= opc;
        s_position <= pos;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(list_apply(opc, pos, val));
    endtask

    // result side: stall, check each beat against the oldest prediction
    always @(posedge aclk) begin : result_sink
        res_t want;
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready)))
            quiet_cycles = 0;
        else if (aresetn)
            quiet_cycles++;
        if (aresetn && m_valid && m_ready) begin
            beats_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: error %0b read_value %08h entry_count %0d",
                             m_error, m_read_value, m_entry_count);
            end else begin
                want = expected_results.pop_front();
                if (m_error !== want.err || m_read_value !== want.rd ||
                    m_entry_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: error exp %0b got %0b, read_value exp %08h got %08h,",
                                  " entry_count exp %0d got %0d"},
                                 want.err, m_error, want.rd, m_read_value,
                                 want.count, m_entry_count);
                end
            end
            sink_wait = sink_idle ? $urandom_range(0, IDLE_MAX) : 0;
        end
        m_ready <= (sink_wait == 0);
        if (sink_wait > 0)
            sink_wait--;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("tb_indexed_list_insert_remove_top NOT OK");
        $finish;
    end

    task automatic test_empty_list;
        send_op(OP_POP, '0, '0);
        send_op(OP_REMOVE, '0, '0);
        send_op(OP_INSERT, POS_W'(1), 32'h1234_5678);
        send_op(OPC_UNDEF, '0, '1);
    endtask

    task automatic test_fill_to_capacity;
        int i;
        send_op(OP_INSERT, '0, 32'hFFFF_FFFF);
        send_op(OP_PUSH, POS_W'(POS_MAX), 32'h0000_0000);
        send_op(OP_INSERT, POS_W'(1), 32'hA5A5_A5A5);
        for (i = 3; i < DEPTH; i++)
            send_op((i % 2) ? OP_PUSH : OP_INSERT, POS_W'(i / 2), $urandom);
        send_op(OP_INSERT, '0, 32'h5A5A_5A5A);
        send_op(OP_PUSH, '0, 32'hDEAD_0001);
    endtask

    task automatic test_shift_and_slots;
        send_op(OP_REMOVE, '0, '0);
        send_op(OP_REMOVE, POS_W'(list_count - 1), '0);
        send_op(OP_REMOVE, POS_W'(list_count), '0);
        send_op(OP_POP, '0, '0);
        send_op(OP_INSERT, POS_W'(list_count), 32'h8000_0001);
        send_op(OP_WRITE, POS_W'(DEPTH), 32'h0BAD_0BAD);
        send_op(OP_READ, POS_W'(POS_MAX), '0);
        send_op(OP_WRITE, POS_W'(DEPTH - 1), 32'h7FFF_FFFE);
        send_op(OP_READ, POS_W'(DEPTH - 1), '0);
        send_op(OP_CLEAR, '0, '0);
        send_op(OP_READ, '0, '0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int               k;
        int               roll;
        traffic_t         mix;
        logic [OPC_W-1:0] opc;
        logic [POS_W-1:0] pos;
        logic [VALUE_W-1:0] val;
        mix = TR_CHURN;
        for (k = 0; k < n_items; k++) begin
            if (k % 50 == 0) begin
                mix       = traffic_t'($urandom_range(0, 2));
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 7))
                0:       val = '0;
                1:       val = '1;
                default: val = $urandom;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                // noise: any opcode, any position
                opc = OPC_W'($urandom_range(0, OPC_MAX));
                pos = POS_W'($urandom_range(0, POS_MAX));
            end else begin
                roll = $urandom_range(0, 99);
                case (mix)
                    TR_GROW:
                        opc = roll < 35 ? OP_INSERT : roll < 68 ? OP_PUSH :
                              roll < 78 ? OP_REMOVE : roll < 83 ? OP_POP :
                              roll < 91 ? OP_WRITE  : roll < 99 ? OP_READ : OP_CLEAR;
                    TR_SHRINK:
                        opc = roll < 8  ? OP_INSERT : roll < 15 ? OP_PUSH :
                              roll < 50 ? OP_REMOVE : roll < 80 ? OP_POP :
                              roll < 89 ? OP_WRITE  : roll < 98 ? OP_READ : OP_CLEAR;
                    default:
                        opc = roll < 18 ? OP_INSERT : roll < 35 ? OP_PUSH :
                              roll < 53 ? OP_REMOVE : roll < 70 ? OP_POP :
                              roll < 83 ? OP_WRITE  : roll < 96 ? OP_READ : OP_CLEAR;
                endcase
                case (opc)
                    OP_INSERT: pos = POS_W'($urandom_range(0, list_count));
                    OP_REMOVE: pos = (list_count == 0) ? '0
                                     : POS_W'($urandom_range(0, list_count - 1));
                    OP_WRITE, OP_READ: pos = POS_W'($urandom_range(0, DEPTH - 1));
                    default:   pos = POS_W'($urandom_range(0, POS_MAX));
                endcase
            end
            send_op(opc, pos, val);
        end
    endtask

    initial begin : main
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_opcode   <= OP_CLEAR;
        s_position <= '0;
        s_value    <= '0;
        m_ready    <= 1'b0;
        list_count = 0;
        for (int i = 0; i < DEPTH; i++)
            list_slots[i] = '0;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_list();
        test_fill_to_capacity();
        test_shift_and_slots();
        test_random_traffic(1720);

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("ops: insert %0d push %0d remove %0d pop %0d write %0d read %0d clear %0d bad %0d",
                 op_hits[OP_INSERT], op_hits[OP_PUSH], op_hits[OP_REMOVE], op_hits[OP_POP],
                 op_hits[OP_WRITE], op_hits[OP_READ], op_hits[OP_CLEAR], op_hits[OPC_UNDEF]);
        $display("%0d rejected, %0d hit a full list; %0d results checked, %0d mismatches",
                 ops_rejected, full_hits, beats_checked, mismatches);
        if (mismatches == 0)
            $display("tb_indexed_list_insert_remove_top OK");
        else
            $display("tb_indexed_list_insert_remove_top NOT OK");
        $finish;
    end

endmodule

// File: files.f
design/ilir_pkg.sv
design/ilir_ram.sv
design/ilir_ctrl.sv
design/indexed_list_insert_remove_top.sv
tb/sv/tb_indexed_list_insert_remove_top.sv
